// File: hw/rtl/i2cs_pkg.sv
// Shared types, codes and helpers for the I2C master transfer sequencer.
// No dependencies.
package i2cs_pkg;

  localparam int LEN_W_DEF = 16;
  localparam int MAX_ACT   = 15;

  localparam logic [2:0] K_READ = 3'd0, K_REGREAD = 3'd1, K_WRITE = 3'd2,
                         K_GRANT = 3'd3, K_EVENT = 3'd4, K_ERROR = 3'd5,
                         K_TIMEOUT = 3'd6, K_RESET = 3'd7;

  localparam logic [3:0] PH_IDLE = 4'd0, PH_WAITBUS = 4'd1, PH_START = 4'd2,
                         PH_ADDRESS = 4'd3, PH_WREG = 4'd4, PH_WDATA = 4'd5,
                         PH_RDATA = 4'd6, PH_STOP = 4'd7, PH_ERROR = 4'd8;

  localparam logic [4:0] A_STEP_END = 5'd0, A_REQ_BUS = 5'd1, A_ARM = 5'd2,
                         A_DISARM = 5'd3, A_ACK = 5'd4, A_POS_OFF = 5'd5,
                         A_POS_ON = 5'd6, A_START = 5'd7, A_STOP = 5'd8,
                         A_WRITE = 5'd9, A_RD_SR2 = 5'd10, A_STORE = 5'd11,
                         A_DISCARD = 5'd12, A_NACK = 5'd13, A_BUF_ON = 5'd14,
                         A_BUF_OFF = 5'd15, A_CLR_ERR = 5'd16, A_RST_PER = 5'd17,
                         A_COMPLETE = 5'd18, A_NOTIFY = 5'd19;

  localparam logic [3:0] R_OK = 4'd0, R_NACK = 4'd1, R_BUS = 4'd2, R_ARB = 4'd3,
                         R_OVR = 4'd4, R_TIMEOUT = 4'd5, R_BAD_STATE = 4'd6,
                         R_BAD_BUF = 4'd7, R_WAIT_FAIL = 4'd8;

  localparam logic [7:0] STRAY_SB_BYTE = 8'h01;

  typedef struct packed {
    logic [4:0]  action;
    logic [23:0] value;
    logic [15:0] pos;
  } act_t;

  // One item's worth of actions, closed by a step end built from code/phase.
  typedef struct packed {
    act_t [MAX_ACT-1:0] acts;
    logic [3:0]         n;
    logic [3:0]         code;
    logic [3:0]         phase;
  } prog_t;

  function automatic prog_t push(prog_t p, logic [4:0] a, logic [23:0] v,
                                 logic [15:0] ps);
    prog_t r;
    r = p;
    if (r.n < 4'(MAX_ACT)) begin
      r.acts[r.n].action = a;
      r.acts[r.n].value  = v;
      r.acts[r.n].pos    = ps;
      r.n = r.n + 4'd1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/i2cs_front.sv
// Front end: accepts items, runs the transfer state and builds the action list.
// Depends on i2cs_pkg.
module i2cs_front #(
  parameter int LENGTH_WIDTH = i2cs_pkg::LEN_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [2:0]         kind,
  input  logic [6:0]         target_address,
  input  logic [7:0]         register_index,
  input  logic [15:0]        transfer_length,
  input  logic [4:0]         event_flags,
  input  logic [4:0]         error_flags,
  input  logic [7:0]         tx_byte,
  input  logic [7:0]         tx_byte_next,
  input  logic [7:0]         rx_first,
  input  logic [7:0]         rx_second,
  input  logic               grant_failed,
  input  logic [15:0]        tmo_base,
  input  logic [7:0]         tmo_per_byte,
  output i2cs_pkg::prog_t    prog
);
  import i2cs_pkg::*;
  localparam int LW = LENGTH_WIDTH;

  logic [3:0]    phase_r, phase_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic [7:0]    reg_r, reg_nxt;
  logic          isrd_r, isrd_nxt, rsp_r, rsp_nxt;
  logic [LW-1:0] len_r, len_nxt, pos_r, pos_nxt;
  logic [3:0]    lres_r, lres_nxt;

  logic [LW-1:0] cmd_len;
  logic [LW:0]   tcnt;
  logic [LW+8:0] tprod;
  logic [23:0]   tval;
  logic          tu, ru;
  logic [7:0]    bv;
  logic [3:0]    code;
  prog_t         p;

  assign cmd_len = transfer_length[LW-1:0];
  assign tcnt    = {1'b0, len_r} + {{LW{1'b0}}, rsp_r};
  assign tprod   = tcnt * tmo_per_byte;
  assign tval    = 24'(32'(tmo_base) + 32'(tprod));

  always_comb begin
    p = '0;
    phase_nxt = phase_r; addr_nxt = addr_r; reg_nxt = reg_r;
    isrd_nxt = isrd_r; rsp_nxt = rsp_r; len_nxt = len_r;
    pos_nxt = pos_r; lres_nxt = lres_r;
    tu = 1'b0; ru = 1'b0; bv = '0; code = R_OK;
    unique case (kind)
      K_READ, K_REGREAD, K_WRITE: begin
        if (phase_r != PH_IDLE) code = R_BAD_STATE;
        else if (cmd_len == '0) code = R_BAD_BUF;
        else begin
          addr_nxt = target_address;
          if (kind == K_REGREAD) reg_nxt = register_index;
          isrd_nxt = (kind != K_WRITE);
          rsp_nxt  = (kind == K_REGREAD);
          len_nxt = cmd_len; pos_nxt = '0; lres_nxt = R_OK;
          phase_nxt = PH_WAITBUS;
          p = push(p, A_REQ_BUS, '0, '0);
        end
      end
      K_GRANT: begin
        if (phase_r == PH_WAITBUS) begin
          if (!grant_failed) begin
            p = push(p, A_ARM, tval, '0);
            phase_nxt = PH_START;
            p = push(p, A_ACK, '0, '0);
            p = push(p, A_POS_OFF, '0, '0);
            p = push(p, A_START, '0, '0);
          end else begin
            p = push(p, A_BUF_OFF, '0, '0);
            p = push(p, A_CLR_ERR, '0, '0);
            p = push(p, A_STOP, '0, '0);
            p = push(p, A_RST_PER, '0, '0);
            lres_nxt = R_WAIT_FAIL; phase_nxt = PH_ERROR;
            p = push(p, A_NOTIFY, '0, '0);
          end
        end
      end
      K_EVENT: begin
        // start sent
        if (event_flags[0]) begin
          if (phase_nxt != PH_START) p = push(p, A_WRITE, 24'(STRAY_SB_BYTE), '0);
          else begin
            phase_nxt = PH_ADDRESS;
            if (isrd_nxt && !rsp_nxt) begin
              p = push(p, A_WRITE, 24'({addr_nxt, 1'b1}), '0);
              if (len_nxt == LW'(2)) p = push(p, A_POS_ON, '0, '0);
            end else p = push(p, A_WRITE, 24'({addr_nxt, 1'b0}), '0);
          end
        end
        // address sent
        if (event_flags[1]) begin
          if (phase_nxt != PH_ADDRESS) p = push(p, A_RD_SR2, '0, '0);
          else if (rsp_nxt) begin
            p = push(p, A_RD_SR2, '0, '0);
            p = push(p, A_WRITE, 24'(reg_nxt), '0);
            p = push(p, A_BUF_ON, '0, '0);
            phase_nxt = PH_WREG;
          end else if (!isrd_nxt) begin
            p = push(p, A_RD_SR2, '0, '0);
            if (pos_nxt < len_nxt) begin
              bv = tu ? tx_byte_next : tx_byte; tu = ~tu;
              p = push(p, A_WRITE, 24'(bv), 16'(pos_nxt));
              pos_nxt = pos_nxt + LW'(1);
            end
            p = push(p, A_BUF_ON, '0, '0);
            phase_nxt = PH_WDATA;
          end else begin
            if (len_nxt == LW'(1)) begin
              p = push(p, A_NACK, '0, '0);
              p = push(p, A_RD_SR2, '0, '0);
              p = push(p, A_STOP, '0, '0);
            end else if (len_nxt == LW'(2)) begin
              p = push(p, A_NACK, '0, '0);
              p = push(p, A_RD_SR2, '0, '0);
            end else p = push(p, A_RD_SR2, '0, '0);
            p = push(p, A_BUF_ON, '0, '0);
            phase_nxt = PH_RDATA;
          end
        end
        // register byte done: repeated start
        if (phase_nxt == PH_WREG && event_flags[2]) begin
          rsp_nxt = 1'b0;
          p = push(p, A_BUF_OFF, '0, '0);
          p = push(p, A_START, '0, '0);
          phase_nxt = PH_START;
        end
        // write data
        if (phase_nxt == PH_WDATA) begin
          if (pos_nxt < len_nxt) begin
            if (event_flags[3]) begin
              bv = tu ? tx_byte_next : tx_byte; tu = ~tu;
              p = push(p, A_WRITE, 24'(bv), 16'(pos_nxt));
              pos_nxt = pos_nxt + LW'(1);
            end
          end else if (event_flags[2]) begin
            p = push(p, A_STOP, '0, '0);
            p = push(p, A_BUF_OFF, '0, '0);
            p = push(p, A_COMPLETE, '0, '0);
            lres_nxt = R_OK; phase_nxt = PH_STOP;
          end
        end
        // read data
        if (phase_nxt != PH_RDATA) begin
          if (event_flags[4]) begin
            ru = ~ru;
            p = push(p, A_DISCARD, '0, '0);
          end
        end else if (len_nxt == LW'(1)) begin
          if (event_flags[4]) begin
            bv = ru ? rx_second : rx_first; ru = ~ru;
            p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
            pos_nxt = pos_nxt + LW'(1);
            p = push(p, A_BUF_OFF, '0, '0);
            p = push(p, A_COMPLETE, '0, '0);
            lres_nxt = R_OK; phase_nxt = PH_STOP;
          end
        end else if (len_nxt == LW'(2)) begin
          if (event_flags[4] && event_flags[2]) begin
            p = push(p, A_STOP, '0, '0);
            bv = ru ? rx_second : rx_first; ru = ~ru;
            p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
            pos_nxt = pos_nxt + LW'(1);
            bv = ru ? rx_second : rx_first; ru = ~ru;
            p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
            pos_nxt = pos_nxt + LW'(1);
            p = push(p, A_BUF_OFF, '0, '0);
            p = push(p, A_COMPLETE, '0, '0);
            lres_nxt = R_OK; phase_nxt = PH_STOP;
          end
        end else if (len_nxt >= LW'(3)) begin
          if (pos_nxt < len_nxt - LW'(3)) begin
            if (event_flags[4]) begin
              bv = ru ? rx_second : rx_first; ru = ~ru;
              p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
              pos_nxt = pos_nxt + LW'(1);
            end
          end else if (pos_nxt == len_nxt - LW'(3)) begin
            if (event_flags[2]) begin
              p = push(p, A_NACK, '0, '0);
              bv = ru ? rx_second : rx_first; ru = ~ru;
              p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
              pos_nxt = pos_nxt + LW'(1);
              p = push(p, A_STOP, '0, '0);
              bv = ru ? rx_second : rx_first; ru = ~ru;
              p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
              pos_nxt = pos_nxt + LW'(1);
            end
          end else if (pos_nxt == len_nxt - LW'(1)) begin
            if (event_flags[4]) begin
              bv = ru ? rx_second : rx_first; ru = ~ru;
              p = push(p, A_STORE, 24'(bv), 16'(pos_nxt));
              pos_nxt = pos_nxt + LW'(1);
              p = push(p, A_BUF_OFF, '0, '0);
              p = push(p, A_COMPLETE, '0, '0);
              lres_nxt = R_OK; phase_nxt = PH_STOP;
            end
          end
        end
      end
      K_ERROR, K_TIMEOUT: begin
        if (kind == K_ERROR) begin
          if (phase_r != PH_IDLE && error_flags != '0) begin
            if (error_flags[0])      lres_nxt = R_NACK;
            else if (error_flags[1]) lres_nxt = R_BUS;
            else if (error_flags[2]) lres_nxt = R_ARB;
            else if (error_flags[3]) lres_nxt = R_OVR;
            else                     lres_nxt = R_TIMEOUT;
            p = push(p, A_BUF_OFF, '0, '0);
            p = push(p, A_CLR_ERR, '0, '0);
            p = push(p, A_STOP, '0, '0);
            p = push(p, A_RST_PER, '0, '0);
            phase_nxt = PH_ERROR;
          end
        end else if (phase_r != PH_IDLE && phase_r != PH_STOP && phase_r != PH_ERROR) begin
          p = push(p, A_BUF_OFF, '0, '0);
          p = push(p, A_CLR_ERR, '0, '0);
          p = push(p, A_STOP, '0, '0);
          p = push(p, A_RST_PER, '0, '0);
          lres_nxt = R_TIMEOUT; phase_nxt = PH_ERROR;
          p = push(p, A_NOTIFY, '0, '0);
        end
      end
      K_RESET: begin
        p = push(p, A_DISARM, '0, '0);
        phase_nxt = PH_IDLE;
      end
      default: ;
    endcase
    p.code  = (kind <= K_WRITE) ? code : lres_nxt;
    p.phase = phase_nxt;
  end

  assign prog = p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; addr_r <= '0; reg_r <= '0; isrd_r <= 1'b0;
      rsp_r <= 1'b0; len_r <= '0; pos_r <= '0; lres_r <= R_OK;
    end else if (accept) begin
      phase_r <= phase_nxt; addr_r <= addr_nxt; reg_r <= reg_nxt;
      isrd_r <= isrd_nxt; rsp_r <= rsp_nxt; len_r <= len_nxt;
      pos_r <= pos_nxt; lres_r <= lres_nxt;
    end
  end
endmodule

// File: hw/rtl/i2cs_queue.sv
// Two-entry queue of action lists between front and back.
// Depends on i2cs_pkg.
module i2cs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_en,
  input  i2cs_pkg::prog_t push_data,
  output logic            full,
  input  logic            pop_en,
  output logic            not_empty,
  output i2cs_pkg::prog_t head,
  output logic [1:0]      count
);
  import i2cs_pkg::*;

  prog_t      mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem[rp_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push_en) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_en) wp_r <= ~wp_r;
      if (pop_en)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_en) - 2'(pop_en);
    end
  end
endmodule

// File: hw/rtl/i2cs_back.sv
// Back end: walks the head action list, one result item per cycle while out_ready is high.
// Depends on i2cs_pkg.
module i2cs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  i2cs_pkg::prog_t head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [4:0]      out_action,
  output logic [23:0]     out_action_value,
  output logic [15:0]     out_position,
  output logic [3:0]      out_result_code,
  output logic [3:0]      out_phase_now,
  output logic            out_last
);
  import i2cs_pkg::*;

  logic [3:0] idx_r;
  logic       vld_r;
  logic       load, at_end;
  act_t       a;

  assign at_end = (idx_r == head.n);
  assign load   = q_valid && (!vld_r || out_ready);
  assign q_pop  = load && at_end;
  assign a      = head.acts[idx_r];
  assign out_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= at_end ? 4'd0 : idx_r + 4'd1;
      end else if (out_ready) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (at_end) begin
        out_action <= A_STEP_END; out_action_value <= '0; out_position <= '0;
        out_result_code <= head.code; out_phase_now <= head.phase;
        out_last <= 1'b1;
      end else begin
        out_action <= a.action; out_action_value <= a.value;
        out_position <= a.pos; out_result_code <= '0; out_phase_now <= '0;
        out_last <= 1'b0;
      end
    end
  end
endmodule

// File: hw/rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: config registers, front,
// queue and back. Depends on i2cs_pkg, i2cs_front, i2cs_queue, i2cs_back.

// Each input item (command, bus grant, event snapshot, error, timeout or
// reset) produces one to sixteen result items: peripheral actions in order,
// closed by a step-end item with last high that carries the phase after the
// item and the result code. The front end decodes an item combinationally
// and queues its whole action list; the back end emits one result per cycle
// while out_ready is high. The two-entry queue lets the front run up to two
// items ahead of the back; once both entries hold lists, in_ready drops until
// the back finishes the head list. The user must write the timeout registers
// only while idle; the block itself does not enforce it.
module i2c_master_transfer_sequencer #(
  parameter int LENGTH_WIDTH = i2cs_pkg::LEN_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [6:0]  in_target_address,
  input  logic [7:0]  in_register_index,
  input  logic [15:0] in_transfer_length,
  input  logic [4:0]  in_event_flags,
  input  logic [4:0]  in_error_flags,
  input  logic [7:0]  in_tx_byte,
  input  logic [7:0]  in_tx_byte_next,
  input  logic [7:0]  in_rx_first,
  input  logic [7:0]  in_rx_second,
  input  logic        in_grant_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_action,
  output logic [23:0] out_action_value,
  output logic [15:0] out_position,
  output logic [3:0]  out_result_code,
  output logic [3:0]  out_phase_now,
  output logic        out_last
);
  import i2cs_pkg::*;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_PER_BYTE = 1'b1;

  logic [15:0] tmo_base_r;
  logic [7:0]  tmo_pb_r;
  logic        accept, q_full, q_ne, q_pop;
  logic [1:0]  q_cnt;
  prog_t       prog, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_base_r <= 16'd25000;
      tmo_pb_r   <= 8'd250;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_BASE)     tmo_base_r <= cfg_wdata;
      if (cfg_index == CFG_PER_BYTE) tmo_pb_r   <= cfg_wdata[7:0];
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  i2cs_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
    .clk, .rst_n, .accept,
    .kind(in_kind), .target_address(in_target_address),
    .register_index(in_register_index), .transfer_length(in_transfer_length),
    .event_flags(in_event_flags), .error_flags(in_error_flags),
    .tx_byte(in_tx_byte), .tx_byte_next(in_tx_byte_next),
    .rx_first(in_rx_first), .rx_second(in_rx_second),
    .grant_failed(in_grant_failed),
    .tmo_base(tmo_base_r), .tmo_per_byte(tmo_pb_r), .prog
  );

  i2cs_queue u_queue (
    .clk, .rst_n, .push_en(accept), .push_data(prog), .full(q_full),
    .pop_en(q_pop), .not_empty(q_ne), .head, .count(q_cnt)
  );

  i2cs_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .head, .q_pop,
    .out_valid, .out_ready, .out_action, .out_action_value, .out_position,
    .out_result_code, .out_phase_now, .out_last
  );

  // queue never holds more than two lists
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt != 2'd3) else $error("queue overflow");
  // a full queue refuses items
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !accept) else $error("push into full queue");
  // last marks only step-end items
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_action == A_STEP_END)
    else $error("last on non step-end item");
  // nothing shows right after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid) else $error("output valid after reset");
endmodule

// File: tb/i2c_master_transfer_sequencer_test.sv
// Self-checking bench for the I2C master transfer sequencer.
// Depends on i2cs_pkg and i2c_master_transfer_sequencer; predicts every action in order.
module i2c_master_transfer_sequencer_test;
  import i2cs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_MAX = 17;
  localparam int HANG_LIMIT = 6000;   // idle cycles before we call it hung
  localparam int DRAIN_WAIT = 40;     // cycles after the last result
  localparam int CFG_BASE = 0, CFG_PER_BYTE = 1;

  localparam logic [4:0] EV_SB = 5'd1, EV_ADDR = 5'd2, EV_BTF = 5'd4,
                         EV_TXE = 5'd8, EV_RXNE = 5'd16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  addr;
    logic [7:0]  regi;
    logic [15:0] len;
    logic [4:0]  ev;
    logic [4:0]  err;
    logic [7:0]  tx0;
    logic [7:0]  tx1;
    logic [7:0]  rx0;
    logic [7:0]  rx1;
    logic        gfail;
  } bus_item_t;

  typedef struct packed {
    logic [4:0]  action;
    logic [23:0] value;
    logic [15:0] pos;
    logic [3:0]  code;
    logic [3:0]  phase;
    logic        last;
  } action_t;

  logic clk, rst_n;
  logic cfg_wr_en, cfg_index;
  logic [15:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  bus_item_t cur;
  action_t got;

  i2c_master_transfer_sequencer u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(cur.kind), .in_target_address(cur.addr), .in_register_index(cur.regi),
    .in_transfer_length(cur.len), .in_event_flags(cur.ev), .in_error_flags(cur.err),
    .in_tx_byte(cur.tx0), .in_tx_byte_next(cur.tx1), .in_rx_first(cur.rx0),
    .in_rx_second(cur.rx1), .in_grant_failed(cur.gfail),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_action(got.action), .out_action_value(got.value), .out_position(got.pos),
    .out_result_code(got.code), .out_phase_now(got.phase), .out_last(got.last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow sequencer state: what the block should hold after each item.
  // ---------------------------------------------------------------------------
  logic [3:0]  sh_phase;
  logic [6:0]  sh_addr;
  logic [7:0]  sh_reg;
  logic        sh_rd, sh_restart;
  logic [15:0] sh_len, sh_pos;
  logic [3:0]  sh_res;
  logic [15:0] tmo_base;
  logic [7:0]  tmo_per_byte;

  action_t   expected_actions[$];
  bus_item_t stim_q[$];
  int n_acts, tx_idx, rx_idx;
  bit failed;

  // The block caps one item's action list at MAX_ACT before the step end.
  task automatic emit(logic [4:0] a, logic [23:0] v, logic [15:0] p);
    action_t r;
    if (n_acts < MAX_ACT) begin
      r = '{action: a, value: v, pos: p, code: 4'd0, phase: 4'd0, last: 1'b0};
      expected_actions.push_back(r);
      n_acts++;
    end
  endtask

  task automatic send_data(bus_item_t it);
    emit(A_WRITE, tx_idx[0] ? it.tx1 : it.tx0, sh_pos);
    tx_idx++;
    sh_pos = sh_pos + 16'd1;
  endtask

  task automatic store_rx(bus_item_t it);
    emit(A_STORE, rx_idx[0] ? it.rx1 : it.rx0, sh_pos);
    rx_idx++;
    sh_pos = sh_pos + 16'd1;
  endtask

  task automatic done_ok();
    emit(A_BUF_OFF, 0, 0);
    emit(A_COMPLETE, 0, 0);
    sh_res = R_OK;
    sh_phase = PH_STOP;
  endtask

  task automatic abort_xfer(logic [3:0] code);
    emit(A_BUF_OFF, 0, 0);
    emit(A_CLR_ERR, 0, 0);
    emit(A_STOP, 0, 0);
    emit(A_RST_PER, 0, 0);
    sh_res = code;
    sh_phase = PH_ERROR;
  endtask

  // Event snapshot: start, address, register, write and read handlers run in turn
  task automatic handle_event(bus_item_t it);
    int n;
    n = sh_len;
    if (it.ev & EV_SB) begin
      if (sh_phase != PH_START) emit(A_WRITE, STRAY_SB_BYTE, 0);
      else begin
        sh_phase = PH_ADDRESS;
        if (sh_rd && !sh_restart) begin
          emit(A_WRITE, {sh_addr, 1'b1}, 0);
          if (sh_len == 16'd2) emit(A_POS_ON, 0, 0);
        end else emit(A_WRITE, {sh_addr, 1'b0}, 0);
      end
    end
    if (it.ev & EV_ADDR) begin
      if (sh_phase != PH_ADDRESS) emit(A_RD_SR2, 0, 0);
      else if (sh_restart) begin
        emit(A_RD_SR2, 0, 0);
        emit(A_WRITE, sh_reg, 0);
        emit(A_BUF_ON, 0, 0);
        sh_phase = PH_WREG;
      end else if (!sh_rd) begin
        emit(A_RD_SR2, 0, 0);
        if (sh_pos < sh_len) send_data(it);
        emit(A_BUF_ON, 0, 0);
        sh_phase = PH_WDATA;
      end else begin
        if (n == 1) begin
          emit(A_NACK, 0, 0); emit(A_RD_SR2, 0, 0); emit(A_STOP, 0, 0);
        end else if (n == 2) begin
          emit(A_NACK, 0, 0); emit(A_RD_SR2, 0, 0);
        end else emit(A_RD_SR2, 0, 0);
        emit(A_BUF_ON, 0, 0);
        sh_phase = PH_RDATA;
      end
    end
    if (sh_phase == PH_WREG && (it.ev & EV_BTF)) begin
      sh_restart = 1'b0;
      emit(A_BUF_OFF, 0, 0);
      emit(A_START, 0, 0);
      sh_phase = PH_START;
    end
    if (sh_phase == PH_WDATA) begin
      if (sh_pos < sh_len) begin
        if (it.ev & EV_TXE) send_data(it);
      end else if (it.ev & EV_BTF) begin
        emit(A_STOP, 0, 0);
        done_ok();
      end
    end
    // Read side; a byte that shows up outside a read is thrown away.
    if (sh_phase != PH_RDATA) begin
      if (it.ev & EV_RXNE) begin
        rx_idx++;
        emit(A_DISCARD, 0, 0);
      end
    end else if (n == 1) begin
      if (it.ev & EV_RXNE) begin store_rx(it); done_ok(); end
    end else if (n == 2) begin
      if ((it.ev & EV_RXNE) && (it.ev & EV_BTF)) begin
        emit(A_STOP, 0, 0); store_rx(it); store_rx(it); done_ok();
      end
    end else if (n >= 3) begin
      if (sh_pos < n - 3) begin
        if (it.ev & EV_RXNE) store_rx(it);
      end else if (sh_pos == n - 3) begin
        if (it.ev & EV_BTF) begin
          emit(A_NACK, 0, 0); store_rx(it); emit(A_STOP, 0, 0); store_rx(it);
        end
      end else if (sh_pos == n - 1) begin
        if (it.ev & EV_RXNE) begin store_rx(it); done_ok(); end
      end
    end
  endtask

  // Works out the full action list one accepted item causes, step end included.
  task automatic predict_actions(bus_item_t it);
    logic [3:0] code;
    logic [31:0] tmo;
    action_t r;
    n_acts = 0; tx_idx = 0; rx_idx = 0;
    code = R_OK;
    case (it.kind)
      K_READ, K_REGREAD, K_WRITE: begin
        if (sh_phase != PH_IDLE) code = R_BAD_STATE;
        else if (it.len == 16'd0) code = R_BAD_BUF;
        else begin
          sh_addr = it.addr;
          if (it.kind == K_REGREAD) sh_reg = it.regi;
          sh_rd = (it.kind != K_WRITE);
          sh_restart = (it.kind == K_REGREAD);
          sh_len = it.len;
          sh_pos = 0;
          sh_res = R_OK;
          sh_phase = PH_WAITBUS;
          emit(A_REQ_BUS, 0, 0);
        end
      end
      K_GRANT: begin
        if (sh_phase == PH_WAITBUS) begin
          if (!it.gfail) begin
            tmo = tmo_base + (sh_len + sh_restart) * tmo_per_byte;
            emit(A_ARM, tmo[23:0], 0);
            sh_phase = PH_START;
            emit(A_ACK, 0, 0); emit(A_POS_OFF, 0, 0); emit(A_START, 0, 0);
          end else begin
            abort_xfer(R_WAIT_FAIL);
            emit(A_NOTIFY, 0, 0);
          end
        end
      end
      K_EVENT: handle_event(it);
      K_ERROR: begin
        // nack wins over bus error, arbitration, overrun, then timeout
        if (sh_phase != PH_IDLE) begin
          if (it.err[0]) abort_xfer(R_NACK);
          else if (it.err[1]) abort_xfer(R_BUS);
          else if (it.err[2]) abort_xfer(R_ARB);
          else if (it.err[3]) abort_xfer(R_OVR);
          else if (it.err[4]) abort_xfer(R_TIMEOUT);
        end
      end
      K_TIMEOUT: begin
        if (sh_phase != PH_IDLE && sh_phase != PH_STOP && sh_phase != PH_ERROR) begin
          abort_xfer(R_TIMEOUT);
          emit(A_NOTIFY, 0, 0);
        end
      end
      default: begin
        emit(A_DISARM, 0, 0);
        sh_phase = PH_IDLE;
      end
    endcase
    r = '{action: A_STEP_END, value: 24'd0, pos: 16'd0,
          code: (it.kind <= K_WRITE) ? code : sh_res, phase: sh_phase, last: 1'b1};
    expected_actions.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pulls items from stim_q, random gap before each one.
  // ---------------------------------------------------------------------------
  bit in_taken, in_busy, out_taken, no_idle;
  int send_gap, recv_stall, hang_cnt;

  function automatic int draw_gap();
    if (no_idle) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_actions(cur);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected result act=%0d val=%0h pos=%0d code=%0d ph=%0d last=%0b",
                   $time, got.action, got.value, got.pos, got.code, got.phase, got.last);
          failed = 1'b1;
        end else begin
          action_t e;
          e = expected_actions.pop_front();
          if (e.action !== got.action || e.value !== got.value || e.pos !== got.pos ||
              e.code !== got.code || e.phase !== got.phase || e.last !== got.last) begin
            $display("%0t: mismatch expected act=%0d val=%0h pos=%0d code=%0d ph=%0d last=%0b",
                     $time, e.action, e.value, e.pos, e.code, e.phase, e.last);
            $display("%0t:          actual   act=%0d val=%0h pos=%0d code=%0d ph=%0d last=%0b",
                     $time, got.action, got.value, got.pos, got.code, got.phase, got.last);
            failed = 1'b1;
          end
        end
      end
      // watchdog: any handshake counts as progress
      if ((in_valid && in_ready) || (out_valid && out_ready)) hang_cnt = 0;
      else hang_cnt++;
      if (hang_cnt >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy = 1'b0;
        send_gap = draw_gap();
      end
      if (!in_busy) begin
        if (send_gap > 0) send_gap--;
        else if (stim_q.size() > 0) begin
          cur <= stim_q.pop_front();
          in_busy = 1'b1;
        end
      end
      in_valid <= in_busy;
      // result side: stall a random number of cycles after each result
      if (out_taken) begin
        out_taken = 1'b0;
        recv_stall = draw_gap();
      end
      if (recv_stall > 0) recv_stall--;
      out_ready <= (recv_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic bus_item_t mk(logic [2:0] k, logic [4:0] ev = 5'd0);
    bus_item_t it;
    logic [95:0] rnd;
    rnd = {$urandom(), $urandom(), $urandom()};
    it = rnd[$bits(bus_item_t)-1:0];     // random operands everywhere
    it.kind = k;
    it.ev = ev;
    it.len = 16'($urandom_range(1, 6));
    return it;
  endfunction

  function automatic bus_item_t err_item(logic [4:0] e);
    bus_item_t it;
    it = mk(K_ERROR);
    it.err = e;
    return it;
  endfunction

  function automatic bus_item_t cmd(logic [2:0] k, logic [15:0] len);
    bus_item_t it;
    it = mk(k);
    it.len = len;
    return it;
  endfunction

  function automatic bus_item_t grant(bit fail);
    bus_item_t it;
    it = mk(K_GRANT);
    it.gfail = fail;
    return it;
  endfunction

  // One well-formed transfer with random content; sometimes broken on purpose.
  task automatic add_transfer();
    logic [2:0] k;
    logic [15:0] len;
    logic [4:0] f;
    int steps;
    k = 3'($urandom_range(0, 2));
    len = ($urandom_range(0, 15) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 6));
    stim_q.push_back(cmd(k, len));
    stim_q.push_back(grant($urandom_range(0, 9) == 0));
    stim_q.push_back(mk(K_EVENT, EV_SB));
    stim_q.push_back(mk(K_EVENT, EV_ADDR));
    if (k == K_REGREAD) begin
      stim_q.push_back(mk(K_EVENT, EV_BTF | EV_TXE));
      stim_q.push_back(mk(K_EVENT, EV_SB));
      stim_q.push_back(mk(K_EVENT, EV_ADDR));
    end
    steps = (len > 8 ? 8 : len) + 2;
    repeat (steps) begin
      case ($urandom_range(0, 9))
        0:       f = 5'($urandom());
        1, 2:    f = EV_BTF | (k == K_WRITE ? EV_TXE : EV_RXNE);
        default: f = (k == K_WRITE) ? EV_TXE : EV_RXNE;
      endcase
      if (k != K_WRITE && $urandom_range(0, 3) == 0) f |= EV_BTF;
      stim_q.push_back(mk(K_EVENT, f));
      if ($urandom_range(0, 24) == 0) stim_q.push_back(err_item(5'($urandom())));
      if ($urandom_range(0, 39) == 0) stim_q.push_back(mk(K_TIMEOUT));
    end
    if ($urandom_range(0, 9) == 0)
      stim_q.push_back(mk(3'($urandom_range(0, 6)), 5'($urandom())));
    stim_q.push_back(mk(K_RESET));
  endtask

  task automatic wait_idle();
    while (stim_q.size() > 0 || in_busy || expected_actions.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Register write at a falling edge; the shadow copy follows right away.
  task automatic write_timeouts(logic [15:0] base, logic [7:0] per_byte);
    cfg_wr_en <= 1'b1; cfg_index <= CFG_BASE[0]; cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_PER_BYTE[0]; cfg_wdata <= {8'd0, per_byte};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tmo_base = base;
    tmo_per_byte = per_byte;
  endtask

  initial begin
    bus_item_t it;
    int budget;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; out_ready = 1'b0; cur = '0;
    sh_phase = PH_IDLE; sh_addr = '0; sh_reg = '0; sh_rd = 0; sh_restart = 0;
    sh_len = '0; sh_pos = '0; sh_res = R_OK;
    tmo_base = 16'd25000; tmo_per_byte = 8'd250;
    failed = 0; hang_cnt = 0; send_gap = 0; recv_stall = 0; no_idle = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle-time noise, every kind, the end sequences and the specials.
    stim_q.push_back(cmd(K_WRITE, 16'd0));          // zero length rejected
    stim_q.push_back(grant(0));                     // stray grant
    stim_q.push_back(err_item(5'h1F));              // error while idle
    stim_q.push_back(mk(K_TIMEOUT));                // timeout while idle
    stim_q.push_back(mk(K_EVENT, 5'h1F));           // stray start, address, rx byte
    it = cmd(K_READ, 16'd1); it.addr = 7'h7F; stim_q.push_back(it);
    stim_q.push_back(cmd(K_WRITE, 16'd3));          // busy command
    stim_q.push_back(grant(0));
    stim_q.push_back(mk(K_EVENT, EV_SB));
    stim_q.push_back(mk(K_EVENT, EV_ADDR));
    stim_q.push_back(mk(K_EVENT, EV_RXNE));         // one-byte read completes
    stim_q.push_back(mk(K_TIMEOUT));                // ignored in stop
    stim_q.push_back(mk(K_RESET));
    it = cmd(K_REGREAD, 16'hFFFF); it.regi = 8'hFF; it.addr = 7'h00; stim_q.push_back(it);
    stim_q.push_back(grant(0));
    stim_q.push_back(mk(K_EVENT, EV_SB));
    stim_q.push_back(mk(K_EVENT, EV_ADDR));
    stim_q.push_back(mk(K_EVENT, EV_BTF));          // repeated start
    stim_q.push_back(err_item(5'h00));              // no flag: ignored
    stim_q.push_back(err_item(5'h10));              // timeout flag aborts
    stim_q.push_back(mk(K_RESET));
    stim_q.push_back(cmd(K_WRITE, 16'd2));
    stim_q.push_back(grant(1));                     // failed bus wait
    stim_q.push_back(mk(K_RESET));
    wait_idle();

    // Several timeout settings, extremes included; the last phase never idles.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_timeouts(16'd0, 8'd0);
        1: write_timeouts(16'hFFFF, 8'hFF);
        2: write_timeouts(16'($urandom()), 8'($urandom()));
        default: write_timeouts(16'd25000, 8'd250);
      endcase
      no_idle = (ph == 3);
      budget = stim_q.size() + 90;
      while (stim_q.size() < budget) begin
        if ($urandom_range(0, 4) == 0) begin
          it = mk(3'($urandom()), 5'($urandom()));  // pure noise, full field range
          it.len = 16'($urandom());
          stim_q.push_back(it);
        end else add_transfer();
      end
      stim_q.push_back(mk(K_RESET));
      wait_idle();
    end

    if (expected_actions.size() == 0 && !failed) $display("simulation ok");
    else begin
      if (expected_actions.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_actions.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/i2cs_pkg.sv
hw/rtl/i2cs_front.sv
hw/rtl/i2cs_queue.sv
hw/rtl/i2cs_back.sv
hw/rtl/i2c_master_transfer_sequencer.sv
tb/i2c_master_transfer_sequencer_test.sv
